@@ design/multiboot_image_encryptor_core_assert.svh @@
// assertion macros used by the encryptor engine rtl
`ifndef MULTIBOOT_IMAGE_ENCRYPTOR_CORE_ASSERT_SVH
`define MULTIBOOT_IMAGE_ENCRYPTOR_CORE_ASSERT_SVH

// condition holds at every edge out of reset
`define MBIE_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define MBIE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define MBIE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/mbie_pkg.sv @@
// shared types and constants of the boot image encryptor
package mbie_pkg;

   localparam int SIZE_W = 19;

   localparam logic [SIZE_W-1:0] MAX_IMAGE_BYTES   = 19'd262144;
   localparam logic [SIZE_W-1:0] MIN_IMAGE_BYTES   = 19'd512;
   localparam logic [SIZE_W-1:0] HEADER_BYTES      = 19'd192;
   localparam logic [SIZE_W-1:0] IMAGE_SIZE_RESET  = 19'd512;

   typedef enum logic {
      FUNC_START = 1'b0,
      FUNC_DATA  = 1'b1
   } func_type;

   typedef struct packed {
      func_type    func;
      logic [31:0] word;
   } in_beat_type;

   typedef struct packed {
      logic [31:0] send_word;
      logic        last;
   } out_beat_type;

endpackage

@@ design/mbie_in_reg.sv @@
// input register in front of the encryption engine
module mbie_in_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  mbie_pkg::in_beat_type in_beat,
   output logic                 hold_valid,
   output mbie_pkg::in_beat_type hold_beat,
   input  logic                 hold_take
);
   import mbie_pkg::*;

   logic        valid_ff, valid_in;
   in_beat_type beat_ff, beat_in;
   logic        fire;

   assign in_ready = !valid_ff || hold_take;
   assign fire     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (fire) begin
         valid_in = 1'b1;
         beat_in  = in_beat;
      end else if (hold_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in;
   end

   assign hold_valid = valid_ff;
   assign hold_beat  = beat_ff;

endmodule

@@ design/mbie_engine.sv @@
// session state, crc and word encryption, one beat per cycle unless stalled
`include "multiboot_image_encryptor_core_assert.svh"

module mbie_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [mbie_pkg::SIZE_W-1:0]   image_size,
   input  logic                          in_valid,
   input  mbie_pkg::in_beat_type         in_beat,
   output logic                          in_take,
   input  logic                          out_free,
   output logic                          res_valid,
   output mbie_pkg::out_beat_type        res_beat
);
   import mbie_pkg::*;

   localparam logic [31:0] KEY_SEED  = 32'h6F64_6573;
   localparam logic [31:0] KEY_MUL   = 32'h6177_614B;
   localparam logic [31:0] KEY_MASK  = 32'h2079_6220;
   localparam logic [31:0] LOAD_BASE = 32'h0200_0000;
   localparam logic [15:0] CRC_POLY  = 16'hA1C1;
   localparam logic [15:0] CRC_INIT  = 16'h15A0;

   typedef logic [31:0][15:0] crc_tab_type;

   // the 32 shift steps are linear, so each input bit maps to a fixed column
   function automatic crc_tab_type crc_build();
      crc_tab_type tab;
      logic [31:0] c;
      for (int b = 0; b < 32; b++) begin
         c = 32'd1 << b;
         for (int s = 0; s < 32; s++) begin
            c = c[0] ? ((c >> 1) ^ {16'd0, CRC_POLY}) : (c >> 1);
         end
         tab[b] = c[15:0];
      end
      return tab;
   endfunction

   localparam crc_tab_type CRC_COL = crc_build();

   function automatic logic [15:0] crc_next(logic [15:0] crc, logic [31:0] val);
      logic [31:0] c;
      logic [15:0] r;
      c = {16'd0, crc} ^ val;
      r = '0;
      for (int i = 0; i < 32; i++) begin
         if (c[i]) begin
            r = r ^ CRC_COL[i];
         end
      end
      return r;
   endfunction

   logic [31:0]       key_ff, key_in;
   logic [15:0]       crc_ff, crc_in;
   logic [SIZE_W-1:0] off_ff, off_in;
   logic              active_ff, active_in;
   logic              trail_ff, trail_in;

   logic [SIZE_W-1:0] size_clamp, size_pad, off_next;
   logic [14:0]       sk_k;
   logic [31:0]       sk_base, sk_sum, sk_full, size_key;
   logic [31:0]       key_step, neg_addr, enc_data, enc_trail;
   logic [15:0]       crc_data;
   logic              in_header, upload_ends, data_step;

   // image size clamped to the maximum, then raised to the minimum or padded to a multiple of 8
   always_comb begin
      size_clamp = (image_size > MAX_IMAGE_BYTES) ? MAX_IMAGE_BYTES : image_size;
      size_pad   = (size_clamp < MIN_IMAGE_BYTES) ? MIN_IMAGE_BYTES
                 : ((size_clamp + 19'd7) & ~19'd7);
   end

   // size key sent in reply to a start beat
   always_comb begin
      sk_k     = 15'((size_pad - MIN_IMAGE_BYTES) >> 3);
      sk_base  = 32'h0070_0000
               | {15'd0, sk_k[14], 1'b0, sk_k[13:7], 1'b0, sk_k[6:0]};
      sk_sum   = sk_base + (sk_base >> 8) + (sk_base >> 16);
      sk_full  = sk_base | {sk_sum[7:0], 24'd0} | 32'h8080_8080;
      size_key = sk_full[9] ? (sk_full ^ KEY_SEED) : (sk_full ^ KEY_MUL);
   end

   // one lcg step, shared by data words and the trailer
   assign key_step    = key_ff * KEY_MUL + 32'd1;
   assign neg_addr    = 32'd0 - (LOAD_BASE + {13'd0, off_ff});
   assign crc_data    = crc_next(crc_ff, in_beat.word);
   assign in_header   = off_ff < HEADER_BYTES;
   assign off_next    = off_ff + 19'd4;
   assign upload_ends = off_next >= size_pad;
   assign enc_data    = in_beat.word ^ key_step ^ neg_addr ^ KEY_MASK;
   // off_ff already points past the last word when the trailer goes out
   assign enc_trail   = {size_pad[15:0], crc_ff} ^ key_step ^ neg_addr ^ KEY_MASK;

   assign in_take   = in_valid && !trail_ff && out_free;
   assign data_step = in_take && (in_beat.func == FUNC_DATA) && active_ff;

   always_comb begin
      key_in    = key_ff;
      crc_in    = crc_ff;
      off_in    = off_ff;
      active_in = active_ff;
      trail_in  = trail_ff;
      res_valid = 1'b0;
      res_beat  = '0;
      if (trail_ff && out_free) begin
         key_in             = key_step;
         trail_in           = 1'b0;
         res_valid          = 1'b1;
         res_beat.send_word = enc_trail;
         res_beat.last      = 1'b1;
      end else if (in_take) begin
         case (in_beat.func)
            FUNC_START: begin
               key_in             = KEY_SEED ^ in_beat.word;
               crc_in             = CRC_INIT;
               off_in             = '0;
               active_in          = 1'b1;
               res_valid          = 1'b1;
               res_beat.send_word = size_key;
            end
            FUNC_DATA: begin
               if (active_ff) begin
                  res_valid = 1'b1;
                  off_in    = off_next;
                  if (in_header) begin
                     res_beat.send_word = in_beat.word;
                  end else begin
                     crc_in             = crc_data;
                     key_in             = key_step;
                     res_beat.send_word = enc_data;
                  end
                  if (upload_ends) begin
                     active_in = 1'b0;
                     trail_in  = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff    <= '0;
         crc_ff    <= CRC_INIT;
         off_ff    <= '0;
         active_ff <= 1'b0;
         trail_ff  <= 1'b0;
      end else begin
         key_ff    <= key_in;
         crc_ff    <= crc_in;
         off_ff    <= off_in;
         active_ff <= active_in;
         trail_ff  <= trail_in;
      end
   end

   `MBIE_ASSERT_IMPLY(a_trail_after_upload, clock, reset, trail_ff, !active_ff, "trailer pending during upload")
   `MBIE_ASSERT_IMPLY(a_res_needs_slot, clock, reset, res_valid, out_free, "result with output slot busy")
   `MBIE_ASSERT_ALWAYS(a_offset_aligned, clock, reset, off_ff[1:0] == 2'b00, "byte offset not word aligned")
   `MBIE_ASSERT_NEXT(a_end_sets_trailer, clock, reset, data_step && upload_ends, trail_ff, "final word without trailer")

endmodule

@@ design/mbie_out_reg.sv @@
// result register toward the transmit side
module mbie_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  res_valid,
   input  mbie_pkg::out_beat_type res_beat,
   output logic                  out_free,
   output logic                  out_valid,
   input  logic                  out_ready,
   output mbie_pkg::out_beat_type out_beat
);
   import mbie_pkg::*;

   logic         valid_ff, valid_in;
   out_beat_type beat_ff, beat_in;

   assign out_free = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (out_free) begin
         valid_in = res_valid;
         if (res_valid) begin
            beat_in = res_beat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in;
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule

@@ design/multiboot_image_encryptor_core.sv @@
// top level of the boot image encryptor
//
//   channel | direction | payload
//   req     | in        | tuser: func, tdata: word
//   rsp     | out       | tdata: send_word, tlast: last
//   csr     | in        | wr_data: image_size
//
// one beat is accepted per cycle when nothing stalls; its result reaches rsp
// through the input register, then the result register.
// the final data word yields two result beats, so the next request beat waits
// while the single lcg multiplier forms the trailer key.
// reset is synchronous; it clears the pipeline valids and session state and
// sets image_size back to 512.
// rsp_tready low holds the result register and stalls req through it.
module multiboot_image_encryptor_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [31:0]                 req_tdata,   // word
   input  logic                        req_tuser,   // func
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [31:0]                 rsp_tdata,   // send_word
   output logic                        rsp_tlast,
   input  logic                        csr_wr_en,
   input  logic [mbie_pkg::SIZE_W-1:0] csr_wr_data
);
   import mbie_pkg::*;

   logic [SIZE_W-1:0] image_size_ff, image_size_in;
   in_beat_type       req_beat, hold_beat;
   out_beat_type      res_beat, out_beat;
   logic              hold_valid, hold_take, out_free, res_valid;

   assign image_size_in = csr_wr_en ? csr_wr_data : image_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_size_ff <= IMAGE_SIZE_RESET;
      end else begin
         image_size_ff <= image_size_in;
      end
   end

   assign req_beat.func = func_type'(req_tuser);
   assign req_beat.word = req_tdata;

   mbie_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_beat    (req_beat),
      .hold_valid (hold_valid),
      .hold_beat  (hold_beat),
      .hold_take  (hold_take)
   );

   mbie_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .image_size (image_size_ff),
      .in_valid   (hold_valid),
      .in_beat    (hold_beat),
      .in_take    (hold_take),
      .out_free   (out_free),
      .res_valid  (res_valid),
      .res_beat   (res_beat)
   );

   mbie_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res_beat   (res_beat),
      .out_free   (out_free),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_beat   (out_beat)
   );

   assign rsp_tdata = out_beat.send_word;
   assign rsp_tlast = out_beat.last;

endmodule
